@@ hdl/collider_table_pair_scanner_assert.svh @@
// Assertion helpers for the collider table pair scanner
`ifndef COLLIDER_TABLE_PAIR_SCANNER_ASSERT_SVH
`define COLLIDER_TABLE_PAIR_SCANNER_ASSERT_SVH
// Check a property on the rising clock edge, disabled while in reset
`define CTPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`endif

@@ hdl/ctps_pkg.sv @@
// ----------------------------------------------------------------------------
// ctps_pkg
// Shared types and constants of the collider table pair scanner.
// ----------------------------------------------------------------------------
package ctps_pkg;
    localparam int SLOTS = 8;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_DESTROY = 2'd1;
    localparam logic [1:0] ACT_SCAN    = 2'd2;

    localparam logic [2:0] RK_ADDED   = 3'd0;
    localparam logic [2:0] RK_DESTROY = 3'd1;
    localparam logic [2:0] RK_IGNORED = 3'd2;
    localparam logic [2:0] RK_FULL    = 3'd3;
    localparam logic [2:0] RK_HIT     = 3'd4;
    localparam logic [2:0] RK_DONE    = 3'd5;

    // Geometry record of one slot: 1+8+8+32+16+16+15+4*17 bits
    typedef struct packed {
        logic               shape;
        logic [7:0]         layer;
        logic [7:0]         mask;
        logic [31:0]        owner;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        radius;
        logic signed [16:0] x0;
        logic signed [16:0] y0;
        logic signed [16:0] x1;
        logic signed [16:0] y1;
    } slot_rec_t;
    localparam int REC_W = $bits(slot_rec_t);
endpackage

@@ hdl/collider_table_pair_scanner.sv @@
// An add or destroy word is loaded in EXEC and made valid from OUT; the next input
// is taken the cycle after it leaves, so one command is handled at a time.
// A scan issues one pair at a time into a two-stage test pipe, waiting until the last
// pair has left it and no result waits; its done word follows once the pipe drains.
// Each result waits in an output register that holds off input and scan while stalled.
// Reset (aresetn low, synchronous) clears generations, counters and the free list.
// ----------------------------------------------------------------------------
// collider_table_pair_scanner
// Collider table with add, destroy and an all-pairs hit scan.
// ----------------------------------------------------------------------------
module collider_table_pair_scanner (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[1:0], shape_kind[2], layer_bits[10:3], mask_bits[18:11],
    // owner_handle[50:19], first_x[66:51], first_y[82:67], second_x[98:83],
    // second_y[114:99], circle_radius[129:115], target_slot[132:130],
    // target_gen[148:133]
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_kind[2:0], slot_a[5:3], gen_a[21:6], slot_b[24:22], gen_b[40:25],
    // layer_a[48:41], layer_b[56:49], owner_a[88:57], owner_b[120:89]
    output logic [127:0] m_tdata,
    output logic         m_tlast
);
    import ctps_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EXEC  = 7'b0000010,
        ST_OUT   = 7'b0000100,
        ST_SCANI = 7'b0001000,
        ST_SCANJ = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [151:0]    cmd_reg;
    logic [15:0]     gen_reg   [SLOTS];
    logic [CW-1:0]   nfree_reg [SLOTS];
    logic [SW-1:0]   alist_reg [SLOTS];
    logic [SW-1:0]   apos_reg  [SLOTS];
    logic [CW-1:0]   free_head_reg;
    logic [CW-1:0]   used_reg;
    logic [CW-1:0]   alive_reg;
    logic [CW-1:0]   i_reg;
    logic [CW-1:0]   j_reg;
    logic            issue_reg;
    logic [SW-1:0]   pa_reg, pb_reg;
    logic [SW-1:0]   qa_reg, qb_reg;
    logic [SW-1:0]   ra_reg, rb_reg;
    logic [127:0]    out_data_reg, out_data_next;
    logic            out_last_reg, out_last_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      hl_a_reg, hl_b_reg, u_ram_hold_la, u_ram_hold_lb;
    logic [31:0]     ho_a_reg, ho_b_reg, u_ram_hold_oa, u_ram_hold_ob;

    logic [1:0]      action;
    logic [SW-1:0]   tslot;
    logic [15:0]     tgen;
    slot_rec_t       new_rec;
    slot_rec_t       rd_a, rd_b;
    logic            wr_en;
    logic [SW-1:0]   wr_slot;
    logic [SW-1:0]   rd_addr_a, rd_addr_b;
    logic            pt_valid, pt_hit;
    logic            out_free;

    assign action = cmd_reg[1:0];
    assign tslot  = cmd_reg[132:130];
    assign tgen   = cmd_reg[148:133];
    assign out_free = !out_valid_reg || m_tready;

    // Build the stored record from the command word
    always_comb begin
        logic signed [15:0] fx, fy, gx, gy;
        logic        [14:0] r;
        fx = cmd_reg[66:51];
        fy = cmd_reg[82:67];
        gx = cmd_reg[98:83];
        gy = cmd_reg[114:99];
        r  = cmd_reg[129:115];
        new_rec.shape = cmd_reg[2];
        new_rec.layer = cmd_reg[10:3];
        new_rec.mask  = cmd_reg[18:11];
        new_rec.owner = cmd_reg[50:19];
        if (!cmd_reg[2]) begin
            new_rec.cx = fx;
            new_rec.cy = fy;
            new_rec.radius = r;
            new_rec.x0 = 17'(fx) - 17'(signed'({1'b0, r}));
            new_rec.y0 = 17'(fy) - 17'(signed'({1'b0, r}));
            new_rec.x1 = 17'(fx) + 17'(signed'({1'b0, r}));
            new_rec.y1 = 17'(fy) + 17'(signed'({1'b0, r}));
        end else begin
            new_rec.cx = '0;
            new_rec.cy = '0;
            new_rec.radius = '0;
            new_rec.x0 = 17'(fx);
            new_rec.y0 = 17'(fy);
            new_rec.x1 = 17'(gx);
            new_rec.y1 = 17'(gy);
        end
    end

    // Slot chosen by an add
    logic [SW-1:0] add_slot;
    logic          add_ok;
    always_comb begin
        add_ok   = (free_head_reg < CW'(SLOTS)) || (used_reg < CW'(SLOTS));
        add_slot = (free_head_reg < CW'(SLOTS)) ? free_head_reg[SW-1:0] : used_reg[SW-1:0];
    end

    // Liveness of the destroy target
    logic          dst_alive;
    logic [SW-1:0] dst_pos;
    always_comb begin
        dst_pos   = apos_reg[tslot];
        dst_alive = (CW'(tslot) < used_reg) && (gen_reg[tslot] == tgen) &&
                    (CW'(dst_pos) < alive_reg) && (alist_reg[dst_pos] == tslot);
    end

    assign wr_en   = (state_reg == ST_EXEC) && (action == ACT_ADD) && add_ok;
    assign wr_slot = add_slot;
    assign rd_addr_a = alist_reg[i_reg[SW-1:0]];
    assign rd_addr_b = alist_reg[j_reg[SW-1:0]];

    // Two record memories so both pair members read in the same cycle
    ctps_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram_a (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_slot), .wr_data(new_rec),
        .rd_addr(rd_addr_a), .rd_data(rd_a)
    );
    ctps_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram_b (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_slot), .wr_data(new_rec),
        .rd_addr(rd_addr_b), .rd_data(rd_b)
    );

    ctps_pair_test u_test (
        .aclk(aclk), .in_valid(issue_reg), .rec_a(rd_a), .rec_b(rd_b),
        .out_valid(pt_valid), .out_hit(pt_hit)
    );

    // Pause issuing while a pair is in the test pipe or the output register cannot take a hit
    logic          can_issue;
    logic          issue_next;
    logic          pending;
    logic [1:0]    inflight_reg;
    assign pending   = (inflight_reg != 2'd0) || issue_reg;
    assign can_issue = !out_valid_reg && !pending;
    // Take new words only when idle, and hold them off while a result still waits
    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;

    always_comb begin
        state_next = state_reg;
        issue_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                priority if (action == ACT_SCAN) begin
                    state_next = ST_SCANI;
                end else if (action == ACT_ADD || action == ACT_DESTROY) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCANI: begin
                if (i_reg + CW'(1) >= alive_reg || alive_reg < CW'(2)) begin
                    state_next = ST_DRAIN;
                end else begin
                    state_next = ST_SCANJ;
                end
            end
            ST_SCANJ: begin
                if (can_issue && out_free) begin
                    issue_next = 1'b1;
                    if (j_reg + CW'(1) >= alive_reg) begin
                        state_next = ST_SCANI;
                    end
                end
            end
            ST_DRAIN: begin
                if (!pending && !out_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Carry layer and owner of the pair alongside the test pipe
    always_ff @(posedge aclk) begin
        hl_a_reg      <= rd_a.layer;
        hl_b_reg      <= rd_b.layer;
        ho_a_reg      <= rd_a.owner;
        ho_b_reg      <= rd_b.owner;
        u_ram_hold_la <= hl_a_reg;
        u_ram_hold_lb <= hl_b_reg;
        u_ram_hold_oa <= ho_a_reg;
        u_ram_hold_ob <= ho_b_reg;
    end

    // Next output word: release on handshake, load answers, hits and done
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_EXEC) begin
            if (action == ACT_ADD) begin
                out_data_next = '0;
                out_last_next = 1'b1;
                if (add_ok) begin
                    out_data_next[2:0]  = RK_ADDED;
                    out_data_next[5:3]  = add_slot;
                    out_data_next[21:6] = gen_reg[add_slot];
                end else begin
                    out_data_next[2:0] = RK_FULL;
                end
            end else if (action == ACT_DESTROY) begin
                out_data_next = '0;
                out_last_next = 1'b1;
                out_data_next[5:3]  = tslot;
                out_data_next[21:6] = tgen;
                out_data_next[2:0]  = dst_alive ? RK_DESTROY : RK_IGNORED;
            end
        end
        if (state_reg == ST_OUT && out_free) begin
            out_valid_next = 1'b1;
        end
        if (pt_valid && pt_hit) begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            out_data_next  = '0;
            out_data_next[2:0]    = RK_HIT;
            out_data_next[5:3]    = ra_reg;
            out_data_next[21:6]   = gen_reg[ra_reg];
            out_data_next[24:22]  = rb_reg;
            out_data_next[40:25]  = gen_reg[rb_reg];
            out_data_next[48:41]  = u_ram_hold_la;
            out_data_next[56:49]  = u_ram_hold_lb;
            out_data_next[88:57]  = u_ram_hold_oa;
            out_data_next[120:89] = u_ram_hold_ob;
        end
        if (state_reg == ST_DONE && out_free) begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            out_data_next  = '0;
            out_data_next[2:0] = RK_DONE;
        end
    end

    // Control and table registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            free_head_reg <= CW'(SLOTS);
            used_reg      <= '0;
            alive_reg     <= '0;
            issue_reg     <= 1'b0;
            inflight_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                gen_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            // Track pairs in the test pipe
            inflight_reg  <= inflight_reg + 2'(issue_reg) - 2'(pt_valid);
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            if (s_tvalid && s_tready) begin
                cmd_reg <= s_tdata;
            end
            if (state_reg == ST_EXEC) begin
                if (action == ACT_ADD) begin
                    if (add_ok) begin
                        if (free_head_reg < CW'(SLOTS)) begin
                            free_head_reg <= nfree_reg[add_slot];
                        end else begin
                            used_reg <= used_reg + CW'(1);
                        end
                        apos_reg[add_slot] <= alive_reg[SW-1:0];
                        alist_reg[alive_reg[SW-1:0]] <= add_slot;
                        alive_reg <= alive_reg + CW'(1);
                    end
                end else if (action == ACT_DESTROY) begin
                    if (dst_alive) begin
                        alist_reg[dst_pos] <= alist_reg[alive_reg[SW-1:0] - SW'(1)];
                        apos_reg[alist_reg[alive_reg[SW-1:0] - SW'(1)]] <= dst_pos;
                        alive_reg <= alive_reg - CW'(1);
                        gen_reg[tslot] <= gen_reg[tslot] + 16'd1;
                        nfree_reg[tslot] <= free_head_reg;
                        free_head_reg <= CW'(tslot);
                    end
                end else if (action == ACT_SCAN) begin
                    i_reg <= '0;
                end
            end
            // Pair counters
            if (state_reg == ST_SCANI && state_next == ST_SCANJ) begin
                j_reg <= i_reg + CW'(1);
            end
            if (state_reg == ST_SCANJ && issue_next) begin
                pa_reg <= rd_addr_a;
                pb_reg <= rd_addr_b;
                if (j_reg + CW'(1) >= alive_reg) begin
                    i_reg <= i_reg + CW'(1);
                end else begin
                    j_reg <= j_reg + CW'(1);
                end
            end
            qa_reg <= pa_reg;
            qb_reg <= pb_reg;
            ra_reg <= qa_reg;
            rb_reg <= qb_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
endmodule

@@ hdl/ctps_ram.sv @@
// ----------------------------------------------------------------------------
// ctps_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module ctps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ hdl/ctps_pair_test.sv @@
// ----------------------------------------------------------------------------
// ctps_pair_test
// Two-stage hit test of one collider pair: layer masks, box overlap, then
// squared distance against squared radius.
// ----------------------------------------------------------------------------
module ctps_pair_test (
    input  logic                aclk,
    input  logic                in_valid,
    input  ctps_pkg::slot_rec_t rec_a,
    input  ctps_pkg::slot_rec_t rec_b,
    output logic                out_valid,
    output logic                out_hit
);
    import ctps_pkg::*;

    logic               s1_valid_reg;
    logic               s1_pass_reg;
    logic               s1_rect_reg;
    logic signed [17:0] s1_dx_reg;
    logic signed [17:0] s1_dy_reg;
    logic        [16:0] s1_rr_reg;
    logic               hit_reg;
    logic               valid_reg;

    logic               mask_ok;
    logic               box_ok;
    slot_rec_t          rct;
    slot_rec_t          cir;
    logic signed [16:0] clx;
    logic signed [16:0] cly;
    logic signed [17:0] dx_next;
    logic signed [17:0] dy_next;
    logic        [16:0] rr_next;
    logic signed [35:0] dx_sq;
    logic signed [35:0] dy_sq;
    logic        [35:0] dsq;
    logic        [33:0] rsq;

    // Stage one: filters, clamp, differences
    always_comb begin
        mask_ok = ((rec_a.mask & rec_b.layer) != '0) && ((rec_b.mask & rec_a.layer) != '0);
        box_ok  = !(rec_a.x1 < rec_b.x0 || rec_a.x0 > rec_b.x1 ||
                    rec_a.y1 < rec_b.y0 || rec_a.y0 > rec_b.y1);
        rct = rec_a.shape ? rec_a : rec_b;
        cir = rec_a.shape ? rec_b : rec_a;
        clx = 17'(cir.cx);
        if (clx < rct.x0) begin
            clx = rct.x0;
        end else if (clx > rct.x1) begin
            clx = rct.x1;
        end
        cly = 17'(cir.cy);
        if (cly < rct.y0) begin
            cly = rct.y0;
        end else if (cly > rct.y1) begin
            cly = rct.y1;
        end
        if (!rec_a.shape && !rec_b.shape) begin
            dx_next = 18'(rec_a.cx) - 18'(rec_b.cx);
            dy_next = 18'(rec_a.cy) - 18'(rec_b.cy);
            rr_next = 17'(rec_a.radius) + 17'(rec_b.radius);
        end else begin
            dx_next = 18'(cir.cx) - 18'(clx);
            dy_next = 18'(cir.cy) - 18'(cly);
            rr_next = 17'(cir.radius);
        end
    end

    always_ff @(posedge aclk) begin
        s1_valid_reg <= in_valid;
        s1_pass_reg  <= mask_ok && box_ok;
        s1_rect_reg  <= rec_a.shape && rec_b.shape;
        s1_dx_reg    <= dx_next;
        s1_dy_reg    <= dy_next;
        s1_rr_reg    <= rr_next;
    end

    // Stage two: full-width squares and strict compare
    always_comb begin
        dx_sq = s1_dx_reg * s1_dx_reg;
        dy_sq = s1_dy_reg * s1_dy_reg;
        dsq   = $unsigned(dx_sq + dy_sq);
        rsq   = s1_rr_reg * s1_rr_reg;
    end

    always_ff @(posedge aclk) begin
        valid_reg <= s1_valid_reg;
        hit_reg   <= s1_pass_reg && (s1_rect_reg || dsq < 36'(rsq));
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;
endmodule

@@ hdl/ctps_checker.sv @@
// ----------------------------------------------------------------------------
// ctps_checker
// Port-level checks of the collider table pair scanner.
// ----------------------------------------------------------------------------
`include "collider_table_pair_scanner_assert.svh"
module ctps_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tlast
);
    import ctps_pkg::*;

    `CTPS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "word dropped")
    `CTPS_ASSERT(a_hit_not_last, m_tvalid && m_tdata[2:0] == RK_HIT |-> !m_tlast, "hit marked last")
    `CTPS_ASSERT(a_other_last, m_tvalid && m_tdata[2:0] != RK_HIT |-> m_tlast, "final not last")
    `CTPS_ASSERT(a_busy, m_tvalid |-> !s_tready, "input taken while result pending")
endmodule

bind collider_table_pair_scanner ctps_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

@@ verif/collider_pair_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// collider_pair_check
// Watches both stream channels of the collider table. It keeps its own copy of
// the slot table, works out the result words that each accepted command
// word must produce, and compares each returned word with the oldest one owed.
// ----------------------------------------------------------------------------
module collider_pair_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [151:0]                  s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [127:0]                  m_tdata,
    input  logic                          m_tlast,
    output int                            mismatches,
    output int                            results_owed,
    output logic [16*ctps_pkg::SLOTS-1:0] slot_gens
);
    import ctps_pkg::*;

    // One result word plus its last flag, kind in the lowest bits
    typedef struct packed {
        logic        last;
        logic [6:0]  pad;
        logic [31:0] owner_b;
        logic [31:0] owner_a;
        logic [7:0]  layer_b;
        logic [7:0]  layer_a;
        logic [15:0] gen_b;
        logic [2:0]  slot_b;
        logic [15:0] gen_a;
        logic [2:0]  slot_a;
        logic [2:0]  kind;
    } result_t;

    result_t owed_results[$];

    // Mirror of the slot table
    logic        shape_rect[SLOTS];
    logic [7:0]  layer_of[SLOTS];
    logic [7:0]  mask_of[SLOTS];
    logic [31:0] owner_of[SLOTS];
    int          cen_x[SLOTS], cen_y[SLOTS], rad[SLOTS];
    int          lo_x[SLOTS], lo_y[SLOTS], hi_x[SLOTS], hi_y[SLOTS];
    logic [15:0] gen_of[SLOTS];
    int          next_free[SLOTS];
    int          free_top, fresh_used, live_count;
    int          live_list[SLOTS], live_pos[SLOTS];

    always_comb begin
        for (int i = 0; i < SLOTS; i++) slot_gens[16*i +: 16] = gen_of[i];
    end

    // Append one owed word at the tail
    function automatic void owe_word(result_t r);
        owed_results.insert(owed_results.size(), r);
    endfunction

    function automatic result_t make_result(logic [2:0] kind, int sa, logic [15:0] ga,
                                            int sb, logic [15:0] gb, logic last);
        result_t r;
        r = '0;
        r.kind = kind;
        r.slot_a = sa[2:0];
        r.gen_a = ga;
        r.slot_b = sb[2:0];
        r.gen_b = gb;
        r.last = last;
        return r;
    endfunction

    function automatic int clamp_to(int p, int lo, int hi);
        if (p < lo) return lo;
        if (p > hi) return hi;
        return p;
    endfunction

    // Strict test of a circle against the nearest point of a rectangle
    function automatic bit rect_touches_circle(int r, int c);
        longint dx, dy, rr;
        dx = cen_x[c] - clamp_to(cen_x[c], lo_x[r], hi_x[r]);
        dy = cen_y[c] - clamp_to(cen_y[c], lo_y[r], hi_y[r]);
        rr = rad[c];
        return dx * dx + dy * dy < rr * rr;
    endfunction

    function automatic bit pair_collides(int a, int b);
        longint dx, dy, rr;
        if ((mask_of[a] & layer_of[b]) == 0 || (mask_of[b] & layer_of[a]) == 0) return 0;
        if (hi_x[a] < lo_x[b] || lo_x[a] > hi_x[b] || hi_y[a] < lo_y[b] || lo_y[a] > hi_y[b])
            return 0;
        if (!shape_rect[a] && !shape_rect[b]) begin
            dx = cen_x[a] - cen_x[b];
            dy = cen_y[a] - cen_y[b];
            rr = rad[a] + rad[b];
            return dx * dx + dy * dy < rr * rr;
        end
        if (shape_rect[a] && !shape_rect[b]) return rect_touches_circle(a, b);
        if (!shape_rect[a] && shape_rect[b]) return rect_touches_circle(b, a);
        return 1;
    endfunction

    // Update the table mirror and queue the words one command owes
    task automatic predict_table_action(logic [151:0] d);
        int      id, p, tail, s, fx, fy, gx, gy, r;
        logic [15:0] g;
        result_t hit;
        case (d[1:0])
            ACT_ADD: begin
                id = -1;
                if (free_top < SLOTS) begin
                    id = free_top;
                    free_top = next_free[id];
                end else if (fresh_used < SLOTS) begin
                    id = fresh_used;
                    fresh_used++;
                    next_free[id] = SLOTS;
                end
                if (id < 0) begin
                    owe_word(make_result(RK_FULL, 0, 16'd0, 0, 16'd0, 1'b1));
                end else begin
                    live_pos[id] = live_count;
                    live_list[live_count] = id;
                    live_count++;
                    shape_rect[id] = d[2];
                    layer_of[id] = d[10:3];
                    mask_of[id] = d[18:11];
                    owner_of[id] = d[50:19];
                    fx = int'($signed(d[66:51]));
                    fy = int'($signed(d[82:67]));
                    gx = int'($signed(d[98:83]));
                    gy = int'($signed(d[114:99]));
                    r = int'({17'b0, d[129:115]});
                    if (!d[2]) begin
                        cen_x[id] = fx; cen_y[id] = fy; rad[id] = r;
                        lo_x[id] = fx - r; lo_y[id] = fy - r;
                        hi_x[id] = fx + r; hi_y[id] = fy + r;
                    end else begin
                        cen_x[id] = 0; cen_y[id] = 0; rad[id] = 0;
                        lo_x[id] = fx; lo_y[id] = fy;
                        hi_x[id] = gx; hi_y[id] = gy;
                    end
                    owe_word(make_result(RK_ADDED, id, gen_of[id], 0, 16'd0, 1'b1));
                end
            end
            ACT_DESTROY: begin
                s = int'(d[132:130]);
                g = d[148:133];
                if (s < fresh_used && gen_of[s] == g && live_pos[s] < live_count
                    && live_list[live_pos[s]] == s) begin
                    p = live_pos[s];
                    tail = live_list[live_count - 1];
                    live_list[p] = tail;
                    live_pos[tail] = p;
                    live_count--;
                    gen_of[s] = gen_of[s] + 16'd1;
                    next_free[s] = free_top;
                    free_top = s;
                    owe_word(make_result(RK_DESTROY, s, g, 0, 16'd0, 1'b1));
                end else begin
                    owe_word(make_result(RK_IGNORED, s, g, 0, 16'd0, 1'b1));
                end
            end
            ACT_SCAN: begin
                for (int i = 0; i < live_count; i++) begin
                    for (int j = i + 1; j < live_count; j++) begin
                        if (pair_collides(live_list[i], live_list[j])) begin
                            hit = make_result(RK_HIT, live_list[i], gen_of[live_list[i]],
                                              live_list[j], gen_of[live_list[j]], 1'b0);
                            hit.layer_a = layer_of[live_list[i]];
                            hit.layer_b = layer_of[live_list[j]];
                            hit.owner_a = owner_of[live_list[i]];
                            hit.owner_b = owner_of[live_list[j]];
                            owe_word(hit);
                        end
                    end
                end
                owe_word(make_result(RK_DONE, 0, 16'd0, 0, 16'd0, 1'b1));
            end
            default: ;
        endcase
    endtask

    // Predict on each command word, check each result word
    always @(posedge aclk) begin
        result_t seen, want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) gen_of[i] = '0;
            free_top = SLOTS;
            fresh_used = 0;
            live_count = 0;
            mismatches = 0;
            owed_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen = {m_tlast, m_tdata};
                if (owed_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%t: unexpected result word kind %0d data %h", $realtime,
                                 seen.kind, m_tdata);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    if (seen != want) begin
                        if (mismatches < 10) begin
                            $display("%t: result mismatch", $realtime);
                            $display("  expected kind %0d last %b data %h",
                                     want.kind, want.last, want[127:0]);
                            $display("  actual   kind %0d last %b data %h",
                                     seen.kind, seen.last, seen[127:0]);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_table_action(s_tdata);
        end
        results_owed <= owed_results.size();
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives commands into the collider table pair scanner: a directed pass over
// full table, stale handles, touching and inverted shapes and extreme values,
// then random add/destroy/scan/unused traffic under four idle and stall phases.
// ----------------------------------------------------------------------------
module tb;
    import ctps_pkg::*;

    // Action code with no meaning; the block answers nothing
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [151:0]        s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [127:0]        m_tdata;
    logic                m_tlast;
    int                  mismatches;
    int                  results_owed;
    logic [16*SLOTS-1:0] slot_gens;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    collider_table_pair_scanner dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    collider_pair_check checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .mismatches(mismatches), .results_owed(results_owed), .slot_gens(slot_gens)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Randomly stall the result channel
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Junk-filled word so that unused fields toggle too
    function automatic logic [151:0] noise_word();
        return 152'({$urandom, $urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic logic [151:0] add_word(logic rect, logic [7:0] layer, logic [7:0] mask,
                                              logic [31:0] owner, logic [15:0] fx,
                                              logic [15:0] fy, logic [15:0] gx,
                                              logic [15:0] gy, logic [14:0] r);
        logic [151:0] d;
        d = noise_word();
        d[1:0] = ACT_ADD;
        d[2] = rect;
        d[10:3] = layer;
        d[18:11] = mask;
        d[50:19] = owner;
        d[66:51] = fx;
        d[82:67] = fy;
        d[98:83] = gx;
        d[114:99] = gy;
        d[129:115] = r;
        return d;
    endfunction

    function automatic logic [151:0] destroy_word(int slot, logic [15:0] g);
        logic [151:0] d;
        d = noise_word();
        d[1:0] = ACT_DESTROY;
        d[132:130] = slot[2:0];
        d[148:133] = g;
        return d;
    endfunction

    function automatic logic [151:0] action_word(logic [1:0] act);
        logic [151:0] d;
        d = noise_word();
        d[1:0] = act;
        return d;
    endfunction

    // Mostly near the origin so shapes meet, sometimes anywhere
    function automatic logic [15:0] pick_coord();
        if ($urandom_range(4) == 0) return 16'($urandom);
        return 16'($urandom_range(400) - 200);
    endfunction

    function automatic logic [14:0] pick_radius();
        if ($urandom_range(4) == 0) return 15'($urandom);
        return 15'($urandom_range(120));
    endfunction

    // Hand one command word over, idling beforehand at random
    task automatic send_word(logic [151:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    initial begin
        int pick, slot;
        logic [15:0] g;
        s_tvalid = 1'b0;
        s_tdata = '0;
        aresetn = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: fill the table with edge shapes, overflow, scan
        send_word(add_word(1'b0, 8'h01, 8'h01, 32'h0000_0001, 16'd0, 16'd0, 16'd0, 16'd0,
                           15'd16));
        // exactly touching circles do not hit
        send_word(add_word(1'b0, 8'h01, 8'h01, 32'hFFFF_FFFF, 16'd32, 16'd0, 16'd0, 16'd0,
                           15'd16));
        send_word(add_word(1'b0, 8'h01, 8'h01, 32'h8000_0000, 16'd31, 16'd0, 16'd0, 16'd0,
                           15'd16));
        send_word(add_word(1'b1, 8'h01, 8'h01, 32'h1234_5678, -16'sd8, -16'sd8, 16'd8, 16'd8,
                           15'd0));
        // inverted rectangle
        send_word(add_word(1'b1, 8'hFF, 8'hFF, 32'h0, 16'd100, 16'd100, 16'd50, 16'd50,
                           15'h7FFF));
        send_word(add_word(1'b0, 8'hFF, 8'hFF, 32'h5555_AAAA, 16'h7FFF, 16'h8000, 16'd0, 16'd0,
                           15'h7FFF));
        // one-way mask, huge rectangle
        send_word(add_word(1'b1, 8'h80, 8'h01, 32'hAAAA_5555, 16'h8000, 16'h8000,
                           16'h7FFF, 16'h7FFF, 15'd0));
        send_word(add_word(1'b0, 8'h00, 8'hFF, 32'h0F0F_F0F0, 16'd0, 16'd0, 16'd0, 16'd0,
                           15'd0));
        send_word(add_word(1'b0, 8'hFF, 8'hFF, 32'h1, 16'd0, 16'd0, 16'd0, 16'd0, 15'd5));
        send_word(action_word(ACT_SCAN));
        // stale, good, then freed slot whose generation matches again
        send_word(destroy_word(2, 16'd1));
        send_word(destroy_word(2, 16'd0));
        send_word(destroy_word(2, 16'd1));
        send_word(destroy_word(0, 16'd0));
        send_word(destroy_word(7, 16'hFFFF));
        send_word(action_word(ACT_SCAN));
        send_word(add_word(1'b0, 8'h01, 8'h01, 32'h77, 16'd4, 16'd4, 16'd0, 16'd0, 15'd20));
        send_word(add_word(1'b1, 8'h01, 8'h01, 32'h99, 16'd10, -16'sd30, 16'd40, 16'd0,
                           15'd0));
        send_word(action_word(ACT_UNUSED));
        send_word(action_word(ACT_SCAN));

        // Random traffic in four phases of sender idling and receiver stalls
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (int n = 0; n < 75; n++) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    send_word(add_word(1'($urandom), 8'($urandom), 8'($urandom), $urandom,
                                       pick_coord(), pick_coord(), pick_coord(),
                                       pick_coord(), pick_radius()));
                end else if (pick < 75) begin
                    slot = $urandom_range(SLOTS - 1);
                    g = slot_gens[16*slot +: 16];
                    if ($urandom_range(9) < 3) g = ($urandom_range(1)) ? 16'($urandom) : g - 16'd1;
                    send_word(destroy_word(slot, g));
                end else if (pick < 95) begin
                    send_word(action_word(ACT_SCAN));
                end else begin
                    send_word(action_word(ACT_UNUSED));
                end
            end
        end

        drain_results();
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ collider_table_pair_scanner.f @@
+incdir+hdl
hdl/ctps_pkg.sv
hdl/ctps_ram.sv
hdl/ctps_pair_test.sv
hdl/collider_table_pair_scanner.sv
hdl/ctps_checker.sv
verif/collider_pair_check.sv
verif/tb.sv
